// ===== rtl/floppy_controller_registers_defines.svh =====
// assertion macros used by the floppy controller rtl
`ifndef FLOPPY_CONTROLLER_REGISTERS_DEFINES_SVH
`define FLOPPY_CONTROLLER_REGISTERS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FCR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("fcr same-cycle check failed");

// next-cycle implication, checked out of reset
`define FCR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("fcr next-cycle check failed");

`endif

// ===== rtl/fdc_pkg.sv =====
package fdc_pkg;

  localparam int SECTOR_BYTES_DEF = 256;
  localparam int DRIVE_COUNT      = 4;
  localparam logic [4:0] DRIVE_LIMIT = 5'(DRIVE_COUNT);

  // transaction kinds
  localparam logic [1:0] CMD_BUS_RD = 2'd0;
  localparam logic [1:0] CMD_BUS_WR = 2'd1;
  localparam logic [1:0] CMD_FILL   = 2'd2;
  localparam logic [1:0] CMD_DRAIN  = 2'd3;

  // register select
  localparam logic [2:0] REG_CMD    = 3'd0;
  localparam logic [2:0] REG_TRACK  = 3'd1;
  localparam logic [2:0] REG_SECTOR = 3'd2;
  localparam logic [2:0] REG_DATA   = 3'd3;
  localparam logic [2:0] REG_DRIVE  = 3'd4;

  // controller command high nibbles
  localparam logic [3:0] OP_RESTORE = 4'h0;
  localparam logic [3:0] OP_SEEK    = 4'h1;
  localparam logic [3:0] OP_READ    = 4'h8;
  localparam logic [3:0] OP_WRITE   = 4'hA;
  localparam logic [7:0] CMD_READ_NO_WAIT = 8'h8C;

  localparam logic [7:0] STATUS_IDLE     = 8'h00;
  localparam logic [7:0] STATUS_BUSY_DRQ = 8'h03;
  localparam logic [7:0] STATUS_BUSY_MASK = 8'hFE;

  // store requests
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_FETCH = 2'd1;
  localparam logic [1:0] REQ_STORE = 2'd2;

  // configuration register indexes and reset values
  localparam logic CFG_SPT   = 1'b0;
  localparam logic CFG_POLLS = 1'b1;
  localparam logic [7:0] SPT_RESET   = 8'd36;
  localparam logic [7:0] POLLS_RESET = 8'd10;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] reg_select;
    logic [7:0] data_in;
    logic [7:0] buffer_offset;
  } in_item_t;

  // what an accepted transaction leaves for the result stage
  typedef struct packed {
    logic        from_mem;
    logic [7:0]  read_data;
    logic        claimed;
    logic [1:0]  store_request;
    logic [1:0]  request_drive;
    logic [15:0] request_sector;
  } stage_info_t;

endpackage

// ===== rtl/fdc_if.sv =====
interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] reg_select;
  logic [7:0] data_in;
  logic [7:0] buffer_offset;

  modport source (output valid, command, reg_select, data_in, buffer_offset,
                  input ready);
  modport sink (input valid, command, reg_select, data_in, buffer_offset,
                output ready);
endinterface

interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        claimed;
  logic [1:0]  store_request;
  logic [1:0]  request_drive;
  logic [15:0] request_sector;

  modport source (output valid, read_data, claimed, store_request, request_drive,
                  request_sector, input ready);
  modport sink (input valid, read_data, claimed, store_request, request_drive,
                request_sector, output ready);
endinterface

// ===== rtl/fdc_buf.sv =====
module fdc_buf #(
  parameter int SECTOR_BYTES = fdc_pkg::SECTOR_BYTES_DEF,
  localparam int AW = $clog2(SECTOR_BYTES)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem_r [SECTOR_BYTES];
  logic [7:0] rdata_r;

  // single port, read data registered and held until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fdc_regs.sv =====
module fdc_regs #(
  parameter int SECTOR_BYTES = fdc_pkg::SECTOR_BYTES_DEF,
  localparam int AW = $clog2(SECTOR_BYTES),
  localparam int OFF_W = ((AW > 8) ? AW : 8) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 accept,
  input  fdc_pkg::in_item_t    item,
  output logic                 mem_en,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_addr,
  output logic [7:0]           mem_wdata,
  output fdc_pkg::stage_info_t info
);

  logic [7:0]    spt_r, polls_r;
  logic [7:0]    status_r, status_nxt;
  logic [7:0]    track_r, track_nxt;
  logic [7:0]    sector_r, sector_nxt;
  logic [7:0]    data_r, data_nxt;
  logic [3:0]    drv_latch_r, drv_latch_nxt;
  logic [3:0]    drv_active_r, drv_active_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic [7:0]    busy_r, busy_nxt;

  logic          count_wrap;
  logic [AW-1:0] count_inc;
  logic [15:0]   lin_sector;
  logic [OFF_W-1:0] off_ext;
  logic [AW-1:0] off_mod;
  logic          drv_ok, drv_latch_ok;

  assign count_wrap = (count_r == AW'(SECTOR_BYTES - 1));
  assign count_inc  = count_wrap ? '0 : count_r + AW'(1);
  assign lin_sector = 16'(track_r) * 16'(spt_r) + 16'(sector_r) - 16'd1;
  assign drv_ok       = ({1'b0, drv_active_r} < fdc_pkg::DRIVE_LIMIT);
  assign drv_latch_ok = ({1'b0, drv_latch_r} < fdc_pkg::DRIVE_LIMIT);

  // offset below twice the buffer size, one compare and subtract
  always_comb begin
    off_ext = OFF_W'(item.buffer_offset);
    if (off_ext >= OFF_W'(SECTOR_BYTES)) begin
      off_ext = off_ext - OFF_W'(SECTOR_BYTES);
    end
    off_mod = AW'(off_ext);
  end

  always_comb begin
    status_nxt     = status_r;
    track_nxt      = track_r;
    sector_nxt     = sector_r;
    data_nxt       = data_r;
    drv_latch_nxt  = drv_latch_r;
    drv_active_nxt = drv_active_r;
    count_nxt      = count_r;
    busy_nxt       = busy_r;
    mem_en         = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = count_r;
    mem_wdata      = item.data_in;
    info           = '0;

    unique case (item.command)
      fdc_pkg::CMD_BUS_RD: begin
        case (item.reg_select)
          fdc_pkg::REG_CMD: begin
            info.claimed = 1'b1;
            if (busy_r == 8'd0) begin
              info.read_data = status_r;
            end else begin
              busy_nxt       = busy_r - 8'd1;
              info.read_data = status_r & fdc_pkg::STATUS_BUSY_MASK;
            end
          end
          fdc_pkg::REG_TRACK: begin
            info.claimed   = 1'b1;
            info.read_data = track_r;
          end
          fdc_pkg::REG_DATA: begin
            info.claimed  = 1'b1;
            info.from_mem = 1'b1;
            mem_en        = 1'b1;
            count_nxt     = count_inc;
            if (count_wrap) begin
              status_nxt = fdc_pkg::STATUS_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      fdc_pkg::CMD_BUS_WR: begin
        case (item.reg_select)
          fdc_pkg::REG_CMD: begin
            case (item.data_in[7:4])
              fdc_pkg::OP_RESTORE: begin
                info.claimed = 1'b1;
                track_nxt    = 8'd0;
                status_nxt   = fdc_pkg::STATUS_IDLE;
              end
              fdc_pkg::OP_SEEK: begin
                info.claimed = 1'b1;
                track_nxt    = data_r;
                status_nxt   = fdc_pkg::STATUS_IDLE;
              end
              fdc_pkg::OP_READ: begin
                info.claimed   = 1'b1;
                busy_nxt       = (item.data_in == fdc_pkg::CMD_READ_NO_WAIT) ? 8'd0 : polls_r;
                status_nxt     = fdc_pkg::STATUS_BUSY_DRQ;
                count_nxt      = '0;
                drv_active_nxt = drv_latch_r;
                if (drv_latch_ok) begin
                  info.store_request  = fdc_pkg::REQ_FETCH;
                  info.request_drive  = drv_latch_r[1:0];
                  info.request_sector = lin_sector;
                end
              end
              fdc_pkg::OP_WRITE: begin
                info.claimed   = 1'b1;
                status_nxt     = fdc_pkg::STATUS_BUSY_DRQ;
                count_nxt      = '0;
                drv_active_nxt = drv_latch_r;
              end
              default: begin
              end
            endcase
          end
          fdc_pkg::REG_TRACK: begin
            info.claimed = 1'b1;
            track_nxt    = item.data_in;
          end
          fdc_pkg::REG_SECTOR: begin
            info.claimed = 1'b1;
            sector_nxt   = item.data_in;
          end
          fdc_pkg::REG_DATA: begin
            info.claimed = 1'b1;
            data_nxt     = item.data_in;
            mem_en       = 1'b1;
            mem_we       = 1'b1;
            count_nxt    = count_inc;
            if (count_wrap) begin
              status_nxt = fdc_pkg::STATUS_IDLE;
              if (drv_ok) begin
                info.store_request  = fdc_pkg::REQ_STORE;
                info.request_drive  = drv_active_r[1:0];
                info.request_sector = lin_sector;
              end
            end
          end
          fdc_pkg::REG_DRIVE: begin
            info.claimed  = 1'b1;
            drv_latch_nxt = item.data_in[3:0];
          end
          default: begin
          end
        endcase
      end
      fdc_pkg::CMD_FILL: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = off_mod;
      end
      fdc_pkg::CMD_DRAIN: begin
        mem_en        = 1'b1;
        mem_addr      = off_mod;
        info.from_mem = 1'b1;
      end
      default: begin
      end
    endcase

    if (!accept) begin
      mem_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r        <= fdc_pkg::SPT_RESET;
      polls_r      <= fdc_pkg::POLLS_RESET;
      status_r     <= '0;
      track_r      <= '0;
      sector_r     <= '0;
      data_r       <= '0;
      drv_latch_r  <= '0;
      drv_active_r <= '0;
      count_r      <= '0;
      busy_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fdc_pkg::CFG_SPT:   spt_r   <= cfg_data;
          fdc_pkg::CFG_POLLS: polls_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        status_r     <= status_nxt;
        track_r      <= track_nxt;
        sector_r     <= sector_nxt;
        data_r       <= data_nxt;
        drv_latch_r  <= drv_latch_nxt;
        drv_active_r <= drv_active_nxt;
        count_r      <= count_nxt;
        busy_r       <= busy_nxt;
      end
    end
  end

endmodule

// ===== rtl/floppy_controller_registers.sv =====
// a result is registered in stage one, then in the output register where it
//   goes valid; stage one holds while the output is full and not taken
// throughput: one transaction per cycle while not stalled; the sector buffer
//   is single-port, used at most once per transaction, with registered reads
// reset (synchronous, rst_n low) clears the pipeline and resets all registers;
//   sector buffer contents stay undefined until written, no clearing pass
`include "floppy_controller_registers_defines.svh"

module floppy_controller_registers #(
  parameter int SECTOR_BYTES = fdc_pkg::SECTOR_BYTES_DEF,
  localparam int AW = $clog2(SECTOR_BYTES)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  fdc_in_if.sink     in_chan,
  fdc_out_if.source  out_chan
);

  fdc_pkg::in_item_t    item;
  fdc_pkg::stage_info_t info, s1_info_r;
  logic                 s1_valid_r;
  logic                 out_valid_r;
  logic [7:0]           out_data_r;
  logic                 out_claimed_r;
  logic [1:0]           out_req_r;
  logic [1:0]           out_drive_r;
  logic [15:0]          out_sector_r;
  logic                 accept, s1_adv;
  logic                 mem_en, mem_we;
  logic [AW-1:0]        mem_addr;
  logic [7:0]           mem_wdata, mem_rdata;

  assign item.command       = in_chan.command;
  assign item.reg_select    = in_chan.reg_select;
  assign item.data_in       = in_chan.data_in;
  assign item.buffer_offset = in_chan.buffer_offset;

  // stage one moves into the output register when that is empty or taken
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign accept        = in_chan.valid && in_chan.ready;

  fdc_regs #(.SECTOR_BYTES(SECTOR_BYTES)) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .info      (info)
  );

  fdc_buf #(.SECTOR_BYTES(SECTOR_BYTES)) u_buf (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info;
    end
    if (s1_adv) begin
      out_data_r    <= s1_info_r.from_mem ? mem_rdata : s1_info_r.read_data;
      out_claimed_r <= s1_info_r.claimed;
      out_req_r     <= s1_info_r.store_request;
      out_drive_r   <= s1_info_r.request_drive;
      out_sector_r  <= s1_info_r.request_sector;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.read_data      = out_data_r;
  assign out_chan.claimed        = out_claimed_r;
  assign out_chan.store_request  = out_req_r;
  assign out_chan.request_drive  = out_drive_r;
  assign out_chan.request_sector = out_sector_r;

  `FCR_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, accept, s1_valid_r)
  `FCR_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_chan.ready,
                  s1_valid_r && out_valid_r && !out_chan.ready)
  `FCR_ASSERT_NOW(a_request_is_claimed, clk, rst_n,
                  out_valid_r && (out_req_r != fdc_pkg::REQ_NONE), out_claimed_r)
  `FCR_ASSERT_NEXT(a_s1_reaches_out, clk, rst_n, s1_adv, out_valid_r)

endmodule

// ===== bench/fdc_register_checker.sv =====
module fdc_register_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  fdc_in_if          in_mon,
  fdc_out_if         out_mon,
  output int         error_count,
  output int         results_due
);

  typedef struct packed {
    logic [7:0]  read_data;
    logic        claimed;
    logic [1:0]  store_request;
    logic [1:0]  request_drive;
    logic [15:0] request_sector;
  } bus_result_t;

  bus_result_t bus_results_due [$];

  // configuration copy
  logic [7:0] spt_cfg;
  logic [7:0] polls_cfg;

  // controller state
  logic [7:0] status_q;
  logic [7:0] track_q;
  logic [7:0] sector_q;
  logic [7:0] latch_q;
  logic [3:0] drive_q;
  logic [3:0] active_drv;
  logic [7:0] data_pos;
  logic [7:0] poll_hold;
  logic [7:0] sector_mem [fdc_pkg::SECTOR_BYTES_DEF];

  fdc_pkg::in_item_t seen_item;
  bus_result_t       want;
  bus_result_t       got;

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(string field, logic [15:0] got_v, logic [15:0] want_v);
    if (got_v !== want_v) begin
      report_error($sformatf("%s: got %0h, expected %0h", field, got_v, want_v));
    end
  endtask

  function automatic logic [15:0] linear_sector();
    logic [31:0] lin;
    lin = 32'(track_q) * 32'(spt_cfg) + 32'(sector_q) - 32'd1;
    return lin[15:0];
  endfunction

  // steps the buffer pointer, true when it wrapped past the last byte
  function automatic bit next_pos();
    data_pos = data_pos + 8'd1;
    return data_pos == 8'd0;
  endfunction

  task automatic apply_access(input fdc_pkg::in_item_t t, output bus_result_t r);
    r = '0;
    case (t.command)
      fdc_pkg::CMD_BUS_RD: begin
        case (t.reg_select)
          fdc_pkg::REG_CMD: begin
            if (poll_hold == 8'd0) begin
              r.read_data = status_q;
            end else begin
              poll_hold = poll_hold - 8'd1;
              r.read_data = status_q & fdc_pkg::STATUS_BUSY_MASK;
            end
            r.claimed = 1'b1;
          end
          fdc_pkg::REG_TRACK: begin
            r.read_data = track_q;
            r.claimed = 1'b1;
          end
          fdc_pkg::REG_DATA: begin
            r.read_data = sector_mem[data_pos];
            if (next_pos()) status_q = fdc_pkg::STATUS_IDLE;
            r.claimed = 1'b1;
          end
          default: ;
        endcase
      end
      fdc_pkg::CMD_BUS_WR: begin
        case (t.reg_select)
          fdc_pkg::REG_CMD: begin
            case (t.data_in[7:4])
              fdc_pkg::OP_RESTORE: begin
                track_q = 8'd0;
                status_q = fdc_pkg::STATUS_IDLE;
                r.claimed = 1'b1;
              end
              fdc_pkg::OP_SEEK: begin
                status_q = fdc_pkg::STATUS_IDLE;
                track_q = latch_q;
                r.claimed = 1'b1;
              end
              fdc_pkg::OP_READ: begin
                poll_hold = (t.data_in == fdc_pkg::CMD_READ_NO_WAIT) ? 8'd0 : polls_cfg;
                status_q = fdc_pkg::STATUS_BUSY_DRQ;
                data_pos = 8'd0;
                active_drv = drive_q;
                if (active_drv < fdc_pkg::DRIVE_COUNT) begin
                  r.store_request = fdc_pkg::REQ_FETCH;
                  r.request_drive = active_drv[1:0];
                  r.request_sector = linear_sector();
                end
                r.claimed = 1'b1;
              end
              fdc_pkg::OP_WRITE: begin
                status_q = fdc_pkg::STATUS_BUSY_DRQ;
                data_pos = 8'd0;
                active_drv = drive_q;
                r.claimed = 1'b1;
              end
              default: ;
            endcase
          end
          fdc_pkg::REG_TRACK: begin
            track_q = t.data_in;
            r.claimed = 1'b1;
          end
          fdc_pkg::REG_SECTOR: begin
            sector_q = t.data_in;
            r.claimed = 1'b1;
          end
          fdc_pkg::REG_DATA: begin
            latch_q = t.data_in;
            sector_mem[data_pos] = t.data_in;
            if (next_pos()) begin
              status_q = fdc_pkg::STATUS_IDLE;
              if (active_drv < fdc_pkg::DRIVE_COUNT) begin
                r.store_request = fdc_pkg::REQ_STORE;
                r.request_drive = active_drv[1:0];
                r.request_sector = linear_sector();
              end
            end
            r.claimed = 1'b1;
          end
          fdc_pkg::REG_DRIVE: begin
            drive_q = t.data_in[3:0];
            r.claimed = 1'b1;
          end
          default: ;
        endcase
      end
      fdc_pkg::CMD_FILL: sector_mem[t.buffer_offset] = t.data_in;
      default: r.read_data = sector_mem[t.buffer_offset];
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      spt_cfg = fdc_pkg::SPT_RESET;
      polls_cfg = fdc_pkg::POLLS_RESET;
      status_q = fdc_pkg::STATUS_IDLE;
      track_q = 8'd0;
      sector_q = 8'd0;
      latch_q = 8'd0;
      drive_q = 4'd0;
      active_drv = 4'd0;
      data_pos = 8'd0;
      poll_hold = 8'd0;
      error_count = 0;
      bus_results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == fdc_pkg::CFG_SPT) spt_cfg = cfg_data;
        else polls_cfg = cfg_data;
      end
      // results first, so a transaction accepted this edge cannot match them
      if (out_mon.valid && out_mon.ready) begin
        got.read_data = out_mon.read_data;
        got.claimed = out_mon.claimed;
        got.store_request = out_mon.store_request;
        got.request_drive = out_mon.request_drive;
        got.request_sector = out_mon.request_sector;
        if (bus_results_due.size() == 0) begin
          report_error($sformatf("result %h with nothing expected", got));
        end else begin
          want = bus_results_due.pop_front();
          compare_field("read_data", 16'(got.read_data), 16'(want.read_data));
          compare_field("claimed", 16'(got.claimed), 16'(want.claimed));
          compare_field("store_request", 16'(got.store_request), 16'(want.store_request));
          compare_field("request_drive", 16'(got.request_drive), 16'(want.request_drive));
          compare_field("request_sector", got.request_sector, want.request_sector);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        seen_item.command = in_mon.command;
        seen_item.reg_select = in_mon.reg_select;
        seen_item.data_in = in_mon.data_in;
        seen_item.buffer_offset = in_mon.buffer_offset;
        apply_access(seen_item, want);
        bus_results_due.push_back(want);
      end
    end
    results_due <= bus_results_due.size();
  end

endmodule

// ===== bench/floppy_controller_registers_tb.sv =====
module floppy_controller_registers_tb;

  localparam int ITEM_BUDGET = 1250;
  localparam int PHASE_COUNT = 6;
  localparam int CYCLE_LIMIT = 800000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  int error_count;
  int results_due;
  int cycle_count;

  // stimulus-side view of the buffer, so no never-written byte is read
  bit byte_known [fdc_pkg::SECTOR_BYTES_DEF];
  int next_byte;
  int items_sent;
  int polls_cur;
  int src_calm;
  int sink_hold;
  int sink_calm;
  int sink_roll;

  fdc_in_if  in_bus ();
  fdc_out_if out_bus ();

  floppy_controller_registers DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  fdc_register_checker reg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .error_count(error_count),
    .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int gap_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, 2);
    if (roll < 96) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // mostly real drives, sometimes a missing one, upper nibble random
  function automatic logic [7:0] drive_value();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(0, 4) != 0) v[3:2] = 2'b00;
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sink_hold = 0;
      sink_calm = 0;
      out_bus.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_bus.ready <= 1'b0;
    end else if (sink_calm > 0) begin
      sink_calm--;
      out_bus.ready <= 1'b1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 60) begin
        out_bus.ready <= 1'b1;
      end else if (sink_roll < 64) begin
        sink_calm = $urandom_range(20, 80);
        out_bus.ready <= 1'b1;
      end else begin
        sink_hold = gap_cycles();
        out_bus.ready <= 1'b0;
      end
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [2:0] sel, input logic [7:0] val,
                      input logic [7:0] off);
    int idle;
    idle = 0;
    if (src_calm > 0) src_calm--;
    else if ($urandom_range(0, 99) < 3) src_calm = $urandom_range(20, 80);
    else if ($urandom_range(0, 99) < 40) idle = gap_cycles() + 1;
    if (cmd == fdc_pkg::CMD_BUS_RD && sel == fdc_pkg::REG_DATA && !byte_known[next_byte])
      cmd = fdc_pkg::CMD_BUS_WR;
    if (cmd == fdc_pkg::CMD_DRAIN && !byte_known[off]) cmd = fdc_pkg::CMD_FILL;
    if (idle > 0) begin
      in_bus.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.command <= cmd;
    in_bus.reg_select <= sel;
    in_bus.data_in <= val;
    in_bus.buffer_offset <= off;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
    if ((cmd == fdc_pkg::CMD_BUS_RD || cmd == fdc_pkg::CMD_BUS_WR) &&
        sel == fdc_pkg::REG_DATA) begin
      if (cmd == fdc_pkg::CMD_BUS_WR) byte_known[next_byte] = 1'b1;
      next_byte = (next_byte + 1) % fdc_pkg::SECTOR_BYTES_DEF;
    end
    if (cmd == fdc_pkg::CMD_BUS_WR && sel == fdc_pkg::REG_CMD &&
        (val[7:4] == fdc_pkg::OP_READ || val[7:4] == fdc_pkg::OP_WRITE))
      next_byte = 0;
    if (cmd == fdc_pkg::CMD_FILL) byte_known[off] = 1'b1;
  endtask

  // called right at an acceptance edge; the checker's count is registered, so it lags
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int         pick;
    int         count;
    bit         full;
    logic [7:0] opcode;
    logic [7:0] fill_at;
    logic [7:0] spt_val;
    logic [7:0] polls_val;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = fdc_pkg::CFG_SPT;
    cfg_data = 8'd0;
    in_bus.valid = 1'b0;
    in_bus.command = fdc_pkg::CMD_BUS_RD;
    in_bus.reg_select = fdc_pkg::REG_CMD;
    in_bus.data_in = 8'd0;
    in_bus.buffer_offset = 8'd0;
    next_byte = 0;
    items_sent = 0;
    polls_cur = fdc_pkg::POLLS_RESET;
    src_calm = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, unhandled selects, buffer edges, every command
    send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_CMD, 8'd0, 8'd0);
    send(fdc_pkg::CMD_BUS_RD, 3'd5, 8'd0, 8'd0);
    send(fdc_pkg::CMD_BUS_RD, 3'd7, 8'hFF, 8'hFF);
    send(fdc_pkg::CMD_FILL, fdc_pkg::REG_CMD, 8'hFF, 8'h00);
    send(fdc_pkg::CMD_FILL, 3'd7, 8'h00, 8'hFF);
    send(fdc_pkg::CMD_DRAIN, fdc_pkg::REG_CMD, 8'd0, 8'hFF);
    send(fdc_pkg::CMD_DRAIN, 3'd6, 8'd0, 8'h00);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_TRACK, 8'hFF, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_SECTOR, 8'h00, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_DRIVE, 8'hF2, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, {fdc_pkg::OP_READ, 4'h1}, 8'd0);
    send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_CMD, 8'd0, 8'd0);
    send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_TRACK, 8'd0, 8'd0);
    send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_SECTOR, 8'd0, 8'd0);
    send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_DRIVE, 8'd0, 8'd0);
    send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_DATA, 8'd0, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_DRIVE, 8'h0F, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, fdc_pkg::CMD_READ_NO_WAIT, 8'd0);
    send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_CMD, 8'd0, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, {fdc_pkg::OP_WRITE, 4'h7}, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_DATA, 8'h5A, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, {fdc_pkg::OP_SEEK, 4'h0}, 8'd0);
    send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_TRACK, 8'd0, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, {fdc_pkg::OP_RESTORE, 4'hF}, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, 8'h20, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, 8'hF0, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, 3'd6, 8'hAA, 8'd0);
    // track 0, sector 0 wraps the linear sector to the top
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_DRIVE, 8'h00, 8'd0);
    send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, {fdc_pkg::OP_READ, 4'h0}, 8'd0);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: begin
            spt_val = 8'd1;
            polls_val = 8'd0;
          end
          2: begin
            spt_val = 8'd255;
            polls_val = 8'd255;
          end
          default: begin
            spt_val = 8'($urandom_range(1, 255));
            polls_val = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
          end
        endcase
        cfg_we <= 1'b1;
        cfg_index <= fdc_pkg::CFG_SPT;
        cfg_data <= spt_val;
        @(posedge clk);
        cfg_index <= fdc_pkg::CFG_POLLS;
        cfg_data <= polls_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        polls_cur = polls_val;
      end

      while (items_sent < (phase + 1) * ITEM_BUDGET / PHASE_COUNT) begin
        pick = $urandom_range(0, 99);
        full = ($urandom_range(0, 9) == 0);
        if (pick < 35) begin
          // sector read: set up, command, store fills buffer, host polls and reads
          if ($urandom_range(0, 2) != 0)
            send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_DRIVE, drive_value(), 8'($urandom));
          if ($urandom_range(0, 1) != 0)
            send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_TRACK, 8'($urandom), 8'($urandom));
          if ($urandom_range(0, 1) != 0)
            send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_SECTOR, 8'($urandom), 8'($urandom));
          opcode = ($urandom_range(0, 3) == 0) ? fdc_pkg::CMD_READ_NO_WAIT
                                                : {fdc_pkg::OP_READ, 4'($urandom)};
          send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, opcode, 8'($urandom));
          count = full ? fdc_pkg::SECTOR_BYTES_DEF : $urandom_range(1, 24);
          fill_at = ($urandom_range(0, 2) != 0) ? 8'd0 : 8'($urandom);
          repeat (count) begin
            send(fdc_pkg::CMD_FILL, 3'($urandom), 8'($urandom), fill_at);
            fill_at++;
          end
          count = ($urandom_range(0, 5) == 0) ? polls_cur + 1 : $urandom_range(0, 4);
          repeat (count) send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_CMD, 8'($urandom), 8'($urandom));
          count = full ? fdc_pkg::SECTOR_BYTES_DEF : $urandom_range(1, 40);
          repeat (count) send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_DATA, 8'($urandom), 8'($urandom));
          send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_CMD, 8'($urandom), 8'($urandom));
        end else if (pick < 65) begin
          // sector write: host fills buffer, last byte sends it to the store
          if ($urandom_range(0, 2) != 0)
            send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_DRIVE, drive_value(), 8'($urandom));
          if ($urandom_range(0, 1) != 0)
            send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_TRACK, 8'($urandom), 8'($urandom));
          if ($urandom_range(0, 1) != 0)
            send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_SECTOR, 8'($urandom), 8'($urandom));
          send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, {fdc_pkg::OP_WRITE, 4'($urandom)},
               8'($urandom));
          count = full ? fdc_pkg::SECTOR_BYTES_DEF : $urandom_range(1, 40);
          repeat (count) send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_DATA, 8'($urandom), 8'($urandom));
          send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_CMD, 8'($urandom), 8'($urandom));
          count = $urandom_range(0, 6);
          repeat (count) send(fdc_pkg::CMD_DRAIN, 3'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 7))
              0: send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_TRACK, 8'($urandom), 8'($urandom));
              1: send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_DATA, 8'($urandom), 8'($urandom));
              2: send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, {fdc_pkg::OP_SEEK, 4'($urandom)},
                      8'($urandom));
              3: send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, {fdc_pkg::OP_RESTORE, 4'($urandom)},
                      8'($urandom));
              4: send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_TRACK, 8'($urandom), 8'($urandom));
              5: send(fdc_pkg::CMD_BUS_RD, fdc_pkg::REG_CMD, 8'($urandom), 8'($urandom));
              6: send(2'($urandom_range(0, 1)),
                      ($urandom_range(0, 1) != 0) ? fdc_pkg::REG_SECTOR : fdc_pkg::REG_DRIVE,
                      8'($urandom), 8'($urandom));
              default: send(fdc_pkg::CMD_BUS_WR, fdc_pkg::REG_CMD, 8'($urandom), 8'($urandom));
            endcase
          end
        end else begin
          repeat ($urandom_range(1, 8))
            send(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
